[hdl/mgfs_pkg.sv]
// Shared widths, register indexes and controller/datapath interface types
// for the masked grid field summary block. Depends on nothing.
`default_nettype none

package mgfs_pkg;

	localparam int FIELD_W    = 32;
	localparam int SUM_W      = 64;
	localparam int GRID_DIM_W = 13;
	localparam int HALO_W     = 12;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam int IN_DATA_W  = 4 * FIELD_W;
	localparam int OUT_USED_W = 4 * SUM_W + 1;
	localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;

	localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HALO_WIDTH  = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic accept;   // capture cell, advance counters
		logic mul;      // volume * density
		logic prod;     // saturate mass, form energy and temperature products
		logic acc;      // add into the accumulators
		logic emit;     // load output register, clear accumulators
	} mgfs_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic counted;   // cell at current position lies outside the halo border
		logic last;      // cell at current position closes the grid
		logic pend_last; // captured cell closed the grid
	} mgfs_stat_t;

endpackage

`default_nettype wire

[hdl/mgfs_ctrl.sv]
// Controller for the masked grid field summary: sequences one cell through
// product, mass and accumulate steps and owns the output valid. Uses mgfs_pkg.
`default_nettype none

module mgfs_ctrl
	import mgfs_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	output logic            m_tvalid,
	input  wire logic       m_tready,
	input  wire mgfs_stat_t stat,
	output mgfs_cmd_t       cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_PROD = 3'd2;
	localparam logic [2:0] ST_ACC  = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_next;
	logic       out_valid_q;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		cmd.accept = s_tvalid && s_tready;
		cmd.mul    = (state_q == ST_MUL);
		cmd.prod   = (state_q == ST_PROD);
		cmd.acc    = (state_q == ST_ACC);
		cmd.emit   = (state_q == ST_EMIT) && (!out_valid_q || m_tready);
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.accept) begin
					if (stat.counted)
						state_next = ST_MUL;
					else if (stat.last)
						state_next = ST_EMIT;
				end
			end
			ST_MUL:  state_next = ST_PROD;
			ST_PROD: state_next = ST_ACC;
			ST_ACC:  state_next = stat.pend_last ? ST_EMIT : ST_IDLE;
			ST_EMIT: begin
				if (cmd.emit)
					state_next = ST_IDLE;
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

[hdl/mgfs_dpath.sv]
// Datapath for the masked grid field summary: position counters, halo mask,
// multiplier steps, saturating accumulators and output register. Uses mgfs_pkg.
`default_nettype none

module mgfs_dpath
	import mgfs_pkg::*;
#(
	parameter int MAX_GRID_DIM = 4096
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [GRID_DIM_W-1:0] grid_width,
	input  wire logic [GRID_DIM_W-1:0] grid_height,
	input  wire logic [HALO_W-1:0]     halo_width,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	output logic      [OUT_DATA_W-1:0] m_tdata,
	input  wire mgfs_cmd_t             cmd,
	output mgfs_stat_t                 stat
);

	localparam int CNT_W = (MAX_GRID_DIM > 1) ? $clog2(MAX_GRID_DIM) : 1;
	localparam int DIM_W = $clog2(MAX_GRID_DIM + 1);
	localparam int CMP_W = ((DIM_W > GRID_DIM_W) ? DIM_W : GRID_DIM_W) + 2;

	logic [CNT_W-1:0]   col_q, row_q;
	logic [CMP_W-1:0]   max_x, w_x, h_x, wcfg_x, hcfg_x, halo_x, col_x, row_x;
	logic               last_col, last_row;

	logic [FIELD_W-1:0] vol_q, dens_q, energy_q, temp_q;
	logic               last_q;
	logic [2*FIELD_W-1:0] prod_s1;
	logic [FIELD_W-1:0] mass_c;
	logic               msat_c;
	logic [FIELD_W-1:0] mass_s2;
	logic               msat_s2;
	logic [2*FIELD_W-1:0] eprod_s2, tprod_s2;

	logic [SUM_W-1:0]   vol_sum_q, mass_sum_q, en_sum_q, tmp_sum_q;
	logic               sat_q;
	logic [SUM_W:0]     vol_add, mass_add, en_add, tmp_add;

	logic [SUM_W-1:0]   out_vol_q, out_mass_q, out_en_q, out_tmp_q;
	logic               out_sat_q;

	// clamp dimensions: zero acts as one, above the maximum acts as the maximum
	always_comb begin
		max_x  = CMP_W'(MAX_GRID_DIM);
		wcfg_x = CMP_W'(grid_width);
		hcfg_x = CMP_W'(grid_height);
		if (wcfg_x == '0)
			w_x = CMP_W'(1);
		else if (wcfg_x > max_x)
			w_x = max_x;
		else
			w_x = wcfg_x;
		if (hcfg_x == '0)
			h_x = CMP_W'(1);
		else if (hcfg_x > max_x)
			h_x = max_x;
		else
			h_x = hcfg_x;
		halo_x = CMP_W'(halo_width);
		col_x  = CMP_W'(col_q);
		row_x  = CMP_W'(row_q);
		last_col = (col_x + CMP_W'(1)) >= w_x;
		last_row = (row_x + CMP_W'(1)) >= h_x;
		stat.counted = (col_x >= halo_x) && ((col_x + halo_x) < w_x) &&
		               (row_x >= halo_x) && ((row_x + halo_x) < h_x);
		stat.last      = last_col && last_row;
		stat.pend_last = last_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.accept) begin
			if (!last_col) begin
				col_q <= col_q + CNT_W'(1);
			end else begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + CNT_W'(1);
			end
		end
	end

	// mass = (volume * density) >> 16, saturated to 32 bits
	always_comb begin
		msat_c = (prod_s1[2*FIELD_W-1:FIELD_W+16] != '0);
		mass_c = msat_c ? '1 : prod_s1[FIELD_W+15:16];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			vol_q    <= s_tdata[FIELD_W-1:0];
			dens_q   <= s_tdata[2*FIELD_W-1:FIELD_W];
			energy_q <= s_tdata[3*FIELD_W-1:2*FIELD_W];
			temp_q   <= s_tdata[4*FIELD_W-1:3*FIELD_W];
			last_q   <= stat.last;
		end
		if (cmd.mul)
			prod_s1 <= vol_q * dens_q;
		if (cmd.prod) begin
			mass_s2  <= mass_c;
			msat_s2  <= msat_c;
			eprod_s2 <= mass_c * energy_q;
			tprod_s2 <= mass_c * temp_q;
		end
	end

	always_comb begin
		vol_add  = {1'b0, vol_sum_q} + (SUM_W+1)'(vol_q);
		mass_add = {1'b0, mass_sum_q} + (SUM_W+1)'(mass_s2);
		en_add   = {1'b0, en_sum_q} + (SUM_W+1)'(eprod_s2[2*FIELD_W-1:16]);
		tmp_add  = {1'b0, tmp_sum_q} + (SUM_W+1)'(tprod_s2[2*FIELD_W-1:16]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vol_sum_q  <= '0;
			mass_sum_q <= '0;
			en_sum_q   <= '0;
			tmp_sum_q  <= '0;
			sat_q      <= 1'b0;
		end else if (cmd.emit) begin
			vol_sum_q  <= '0;
			mass_sum_q <= '0;
			en_sum_q   <= '0;
			tmp_sum_q  <= '0;
			sat_q      <= 1'b0;
		end else if (cmd.acc) begin
			vol_sum_q  <= vol_add[SUM_W]  ? '1 : vol_add[SUM_W-1:0];
			mass_sum_q <= mass_add[SUM_W] ? '1 : mass_add[SUM_W-1:0];
			en_sum_q   <= en_add[SUM_W]   ? '1 : en_add[SUM_W-1:0];
			tmp_sum_q  <= tmp_add[SUM_W]  ? '1 : tmp_add[SUM_W-1:0];
			sat_q      <= sat_q | msat_s2 | vol_add[SUM_W] | mass_add[SUM_W] |
			              en_add[SUM_W] | tmp_add[SUM_W];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_vol_q  <= vol_sum_q;
			out_mass_q <= mass_sum_q;
			out_en_q   <= en_sum_q;
			out_tmp_q  <= tmp_sum_q;
			out_sat_q  <= sat_q;
		end
	end

	assign m_tdata = {(OUT_DATA_W - OUT_USED_W)'(0), out_sat_q,
	                  out_tmp_q, out_en_q, out_mass_q, out_vol_q};

endmodule

`default_nettype wire

[hdl/masked_grid_field_summary.sv]
// Top level of the masked grid field summary: configuration registers,
// controller and datapath. Uses mgfs_pkg, mgfs_ctrl and mgfs_dpath.
//
//  channel  | direction | transfer when          | payload
//  ---------+-----------+------------------------+------------------------------------
//  s_*      | in        | s_tvalid && s_tready   | one grid cell, four Q16.16 fields
//  m_*      | out       | m_tvalid && m_tready   | grid totals (Q48.16) and sat flag
//  cfg_*    | in        | cfg_wen high           | grid_width, grid_height, halo_width
//
// A halo border cell is only captured. An interior cell takes four steps:
// capture, volume * density, mass saturation with the energy and temperature
// products, then the accumulate. The last cell of a grid adds a step to load
// the output register, and waits there while an earlier result is still not
// taken by the sink. A result waiting in the output register does not block
// new cells. Reset clears counters, sums, the flag and the output valid and
// loads the configuration defaults (16 x 16 cells, halo 2).
`default_nettype none

module masked_grid_field_summary
	import mgfs_pkg::*;
#(
	parameter int MAX_GRID_DIM = 4096
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// cell_volume [31:0], cell_density [63:32], cell_energy [95:64],
	// cell_temperature [127:96]
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// total_volume [63:0], total_mass [127:64], total_energy [191:128],
	// total_temperature [255:192], any_saturated [256], zero fill [263:257]
	output logic      [OUT_DATA_W-1:0] m_tdata,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	input  wire logic                  cfg_wen,
	input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	logic [GRID_DIM_W-1:0] grid_width_q;
	logic [GRID_DIM_W-1:0] grid_height_q;
	logic [HALO_W-1:0]     halo_width_q;
	mgfs_cmd_t             cmd;
	mgfs_stat_t            stat;

	// configuration registers; an index past the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= GRID_DIM_W'(16);
			grid_height_q <= GRID_DIM_W'(16);
			halo_width_q  <= HALO_W'(2);
		end else if (cfg_wen) begin
			case (cfg_addr)
				CFG_GRID_WIDTH:  grid_width_q  <= cfg_wdata[GRID_DIM_W-1:0];
				CFG_GRID_HEIGHT: grid_height_q <= cfg_wdata[GRID_DIM_W-1:0];
				CFG_HALO_WIDTH:  halo_width_q  <= cfg_wdata[HALO_W-1:0];
				default: ;
			endcase
		end
	end

	mgfs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	mgfs_dpath #(
		.MAX_GRID_DIM (MAX_GRID_DIM)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.grid_width  (grid_width_q),
		.grid_height (grid_height_q),
		.halo_width  (halo_width_q),
		.s_tdata     (s_tdata),
		.m_tdata     (m_tdata),
		.cmd         (cmd),
		.stat        (stat)
	);

endmodule

`default_nettype wire

[hdl/mgfs_checker.sv]
// Port-level checker for masked_grid_field_summary, attached by bind.
// Uses mgfs_pkg.
`default_nettype none

module mgfs_checker
	import mgfs_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  s_tready,
	input wire logic [OUT_DATA_W-1:0] m_tdata,
	input wire logic                  m_tvalid,
	input wire logic                  m_tready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");

	// a result is loaded only from the emit step, which holds off new cells
	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result appeared without an emit step");

	// zero mass gives zero products in every counted cell
	a_mass_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[127:64] == 64'd0) |->
			(m_tdata[191:128] == 64'd0) && (m_tdata[255:192] == 64'd0))
		else $error("energy or temperature total without mass");

	// zero volume gives zero mass in every counted cell
	a_vol_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[63:0] == 64'd0) |-> (m_tdata[127:64] == 64'd0))
		else $error("mass total without volume");

endmodule

bind masked_grid_field_summary mgfs_checker u_mgfs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tdata  (m_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready)
);

`default_nettype wire
